// ===== design/rase_pkg.sv =====
`timescale 1ns / 1ps
package rase_pkg;

  localparam logic [4:0] FN_ADD    = 5'd0;
  localparam logic [4:0] FN_SUB    = 5'd1;
  localparam logic [4:0] FN_AND    = 5'd2;
  localparam logic [4:0] FN_XOR    = 5'd3;
  localparam logic [4:0] FN_OR     = 5'd4;
  localparam logic [4:0] FN_ADDI   = 5'd5;
  localparam logic [4:0] FN_SUBI   = 5'd6;
  localparam logic [4:0] FN_ANDI   = 5'd7;
  localparam logic [4:0] FN_XORI   = 5'd8;
  localparam logic [4:0] FN_ORI    = 5'd9;
  localparam logic [4:0] FN_MOVREG = 5'd10;
  localparam logic [4:0] FN_MOVIMM = 5'd11;
  localparam logic [4:0] FN_SWAP   = 5'd12;
  localparam logic [4:0] FN_DIV    = 5'd13;
  localparam logic [4:0] FN_PUSH   = 5'd14;
  localparam logic [4:0] FN_POP    = 5'd15;
  localparam logic [4:0] FN_SKIPEQ = 5'd16;
  localparam logic [4:0] FN_SQUARE = 5'd17;

  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_FULL  = 2'd1;
  localparam logic [1:0] ERR_EMPTY = 2'd2;
  localparam logic [1:0] ERR_DIV0  = 2'd3;

  typedef struct packed {
    logic [4:0]         func;
    logic [4:0]         dest_reg;
    logic [4:0]         src_a_reg;
    logic [4:0]         src_b_reg;
    logic signed [31:0] immediate;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic signed [31:0] second_value;
    logic               parity_flag;
    logic               zero_flag;
    logic               sign_flag;
    logic               overflow_flag;
    logic [1:0]         error_code;
    logic               skipped;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_ITER,
    ST_FIN,
    ST_WR2
  } state_t;

endpackage

// ===== design/rase_ram.sv =====
`timescale 1ns / 1ps
module rase_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr0,
  output logic [WIDTH-1:0]                      rdata0,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr1,
  output logic [WIDTH-1:0]                      rdata1
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule

// ===== design/rase_front.sv =====
`timescale 1ns / 1ps
module rase_front
  import rase_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  in_item_t item,
  output logic     busy,
  input  logic     pop,
  output logic     head_valid,
  output in_item_t head
);

  // two-entry queue between accept and execute
  in_item_t   ent_r [2];
  logic       wptr_r, wptr_nxt;
  logic       rptr_r, rptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;

  assign busy       = (cnt_r == 2'd2);
  assign push       = start && !busy;
  assign head_valid = (cnt_r != 2'd0);
  assign head       = ent_r[rptr_r];

  always_comb begin
    wptr_nxt = push ? ~wptr_r : wptr_r;
    rptr_nxt = (pop && head_valid) ? ~rptr_r : rptr_r;
    cnt_nxt  = cnt_r + 2'(push) - 2'(pop && head_valid);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wptr_r] <= item;
    end
  end

endmodule

// ===== design/rase_back.sv =====
`timescale 1ns / 1ps
module rase_back
  import rase_pkg::*;
#(
  parameter int REG_COUNT   = 32,
  parameter int STACK_DEPTH = 32,
  parameter int DATA_WIDTH  = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      head_valid,
  input  in_item_t  head,
  output logic      pop,
  output logic      out_valid,
  output out_item_t out_item
);

  localparam int RIW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
  localparam int SAW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int SPW = $clog2(STACK_DEPTH + 1);
  localparam int CW  = $clog2(DATA_WIDTH + 1);
  localparam int W   = DATA_WIDTH;

  function automatic logic [RIW-1:0] reg_idx(input logic [4:0] r);
    return RIW'(32'(r) % REG_COUNT);
  endfunction

  function automatic logic [31:0] to_out(input logic [W-1:0] v);
    logic [63:0] t;
    t = 64'(v);
    return t[31:0];
  endfunction

  state_t         state_r, state_nxt;
  in_item_t       cur_r, cur_nxt;
  logic           skip_r, skip_nxt;
  logic [SPW-1:0] sp_r, sp_nxt;
  logic           fp_r, fz_r, fs_r, fv_r;
  logic           fp_nxt, fz_nxt, fs_nxt, fv_nxt;
  logic           valid_r [REG_COUNT];
  logic           vld0_r, vld1_r;
  logic [W-1:0]   fst_r, fst_nxt, sec_r, sec_nxt;
  logic [W-1:0]   rem_r, rem_nxt, q_r, q_nxt, um_r, um_nxt;
  logic           nneg_r, nneg_nxt, mneg_r, mneg_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic           emit;
  out_item_t      out_r, out_nxt;
  logic           out_valid_r;

  logic [RIW-1:0] hd, ha, hb, cd, ca, ra0, ra1, rf_wa;
  logic           rf_we, st_we;
  logic [W-1:0]   rf_wd, rd0, rd1, st_rd, op0, op1, y, v, flag_src;
  logic           set_flags;
  logic [63:0]    imm_ext;
  logic [W-1:0]   trial, qf, rf;
  logic           ge;

  assign hd  = reg_idx(head.dest_reg);
  assign ha  = reg_idx(head.src_a_reg);
  assign hb  = reg_idx(head.src_b_reg);
  assign cd  = reg_idx(cur_r.dest_reg);
  assign ca  = reg_idx(cur_r.src_a_reg);
  assign ra0 = (head.func <= FN_MOVREG) ? ha : hd;
  assign ra1 = (head.func <= FN_OR) ? hb : ha;
  assign pop = (state_r == ST_IDLE) && head_valid;

  rase_ram #(.WIDTH(W), .DEPTH(REG_COUNT)) u_regs (
    .clk(clk), .we(rf_we), .waddr(rf_wa), .wdata(rf_wd),
    .raddr0(ra0), .rdata0(rd0), .raddr1(ra1), .rdata1(rd1)
  );

  rase_ram #(.WIDTH(W), .DEPTH(STACK_DEPTH)) u_stack (
    .clk(clk), .we(st_we), .waddr(sp_r[SAW-1:0]), .wdata(op0),
    .raddr0(SAW'(sp_r - 1'b1)), .rdata0(st_rd), .raddr1(sp_r[SAW-1:0]), .rdata1()
  );

  // never-written registers read as zero
  assign op0     = vld0_r ? rd0 : '0;
  assign op1     = vld1_r ? rd1 : '0;
  assign imm_ext = 64'(cur_r.immediate);
  assign y       = (cur_r.func <= FN_OR) ? op1 : imm_ext[W-1:0];
  assign trial   = {rem_r[W-2:0], q_r[W-1]};
  assign ge      = (trial >= um_r);
  assign qf      = (nneg_r != mneg_r) ? W'(-q_r) : q_r;
  assign rf      = nneg_r ? W'(-rem_r) : rem_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (head_valid) state_nxt = ST_EXEC;
      ST_EXEC: begin
        if (skip_r) state_nxt = ST_IDLE;
        else if (cur_r.func == FN_SWAP) state_nxt = ST_WR2;
        else if (cur_r.func == FN_DIV) state_nxt = (op1 == '0) ? ST_IDLE : ST_ITER;
        else if (cur_r.func == FN_SQUARE) state_nxt = ST_ITER;
        else state_nxt = ST_IDLE;
      end
      ST_ITER: if (cnt_r == CW'(1)) state_nxt = ST_FIN;
      ST_FIN:  state_nxt = (cur_r.func == FN_DIV) ? ST_WR2 : ST_IDLE;
      ST_WR2:  state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cur_nxt   = pop ? head : cur_r;
    skip_nxt  = skip_r;
    sp_nxt    = sp_r;
    fv_nxt    = fv_r;
    fst_nxt   = fst_r;
    sec_nxt   = sec_r;
    rem_nxt   = rem_r;
    q_nxt     = q_r;
    um_nxt    = um_r;
    nneg_nxt  = nneg_r;
    mneg_nxt  = mneg_r;
    cnt_nxt   = cnt_r;
    rf_we     = 1'b0;
    rf_wa     = cd;
    rf_wd     = '0;
    st_we     = 1'b0;
    set_flags = 1'b0;
    flag_src  = '0;
    v         = '0;
    emit      = 1'b0;
    out_nxt   = '0;
    unique case (state_r)
      ST_IDLE: ;
      ST_EXEC: begin
        emit = 1'b1;
        if (skip_r) begin
          skip_nxt        = 1'b0;
          out_nxt.skipped = 1'b1;
        end else begin
          unique case (cur_r.func)
            FN_ADD, FN_SUB, FN_AND, FN_XOR, FN_OR,
            FN_ADDI, FN_SUBI, FN_ANDI, FN_XORI, FN_ORI: begin
              unique case (cur_r.func)
                FN_ADD, FN_ADDI: begin
                  v      = op0 + y;
                  fv_nxt = (op0[W-1] == y[W-1]) && (v[W-1] != op0[W-1]);
                end
                FN_SUB, FN_SUBI: begin
                  v      = op0 - y;
                  fv_nxt = (op0[W-1] != y[W-1]) && (v[W-1] != op0[W-1]);
                end
                FN_AND, FN_ANDI: v = op0 & y;
                FN_XOR, FN_XORI: v = op0 ^ y;
                default:         v = op0 | y;
              endcase
              rf_we                = 1'b1;
              rf_wd                = v;
              set_flags            = 1'b1;
              flag_src             = v;
              out_nxt.result_value = to_out(v);
            end
            FN_MOVREG: begin
              rf_we                = 1'b1;
              rf_wd                = op0;
              out_nxt.result_value = to_out(op0);
            end
            FN_MOVIMM: begin
              rf_we                = 1'b1;
              rf_wd                = imm_ext[W-1:0];
              out_nxt.result_value = to_out(imm_ext[W-1:0]);
            end
            FN_SWAP: begin
              // dest gets a now, a gets the old dest in the second write
              emit    = 1'b0;
              rf_we   = 1'b1;
              rf_wd   = op1;
              fst_nxt = op1;
              sec_nxt = op0;
            end
            FN_DIV: begin
              if (op1 == '0) begin
                out_nxt.error_code = ERR_DIV0;
              end else begin
                emit     = 1'b0;
                nneg_nxt = op0[W-1];
                mneg_nxt = op1[W-1];
                q_nxt    = op0[W-1] ? W'(-op0) : op0;
                um_nxt   = op1[W-1] ? W'(-op1) : op1;
                rem_nxt  = '0;
                cnt_nxt  = CW'(W);
              end
            end
            FN_SQUARE: begin
              emit    = 1'b0;
              q_nxt   = op0;
              um_nxt  = op0;
              rem_nxt = '0;
              cnt_nxt = CW'(W);
            end
            FN_PUSH: begin
              if (sp_r >= SPW'(STACK_DEPTH)) begin
                out_nxt.error_code = ERR_FULL;
              end else begin
                st_we                = 1'b1;
                sp_nxt               = sp_r + 1'b1;
                out_nxt.result_value = to_out(op0);
              end
            end
            FN_POP: begin
              if (sp_r == '0) begin
                out_nxt.error_code = ERR_EMPTY;
              end else begin
                sp_nxt               = sp_r - 1'b1;
                rf_we                = 1'b1;
                rf_wd                = st_rd;
                out_nxt.result_value = to_out(st_rd);
              end
            end
            FN_SKIPEQ: skip_nxt = (op0 == op1);
            default: ;
          endcase
        end
      end
      ST_ITER: begin
        cnt_nxt = cnt_r - 1'b1;
        if (cur_r.func == FN_DIV) begin
          rem_nxt = ge ? trial - um_r : trial;
          q_nxt   = {q_r[W-2:0], ge};
        end else begin
          // shift-add, low half only
          rem_nxt = q_r[0] ? rem_r + um_r : rem_r;
          um_nxt  = um_r << 1;
          q_nxt   = q_r >> 1;
        end
      end
      ST_FIN: begin
        rf_we = 1'b1;
        if (cur_r.func == FN_DIV) begin
          rf_wd     = qf;
          fst_nxt   = qf;
          sec_nxt   = rf;
          set_flags = 1'b1;
          // with dest equal to a the remainder lands last
          flag_src  = (cd == ca) ? rf : qf;
        end else begin
          emit                 = 1'b1;
          rf_wd                = rem_r;
          out_nxt.result_value = to_out(rem_r);
        end
      end
      ST_WR2: begin
        emit                 = 1'b1;
        rf_we                = 1'b1;
        rf_wa                = ca;
        rf_wd                = sec_r;
        out_nxt.result_value = to_out(fst_r);
        out_nxt.second_value = to_out(sec_r);
      end
      default: ;
    endcase
    fp_nxt = set_flags ? (!flag_src[W-1] && ^flag_src) : fp_r;
    fz_nxt = set_flags ? (flag_src == '0) : fz_r;
    fs_nxt = set_flags ? flag_src[W-1] : fs_r;
    out_nxt.parity_flag   = fp_nxt;
    out_nxt.zero_flag     = fz_nxt;
    out_nxt.sign_flag     = fs_nxt;
    out_nxt.overflow_flag = fv_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      skip_r      <= 1'b0;
      sp_r        <= '0;
      fp_r        <= 1'b0;
      fz_r        <= 1'b0;
      fs_r        <= 1'b0;
      fv_r        <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < REG_COUNT; i++) begin
        valid_r[i] <= 1'b0;
      end
    end else begin
      state_r     <= state_nxt;
      skip_r      <= skip_nxt;
      sp_r        <= sp_nxt;
      fp_r        <= fp_nxt;
      fz_r        <= fz_nxt;
      fs_r        <= fs_nxt;
      fv_r        <= fv_nxt;
      out_valid_r <= emit;
      if (rf_we) begin
        valid_r[rf_wa] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;
    vld0_r <= valid_r[ra0];
    vld1_r <= valid_r[ra1];
    fst_r  <= fst_nxt;
    sec_r  <= sec_nxt;
    rem_r  <= rem_nxt;
    q_r    <= q_nxt;
    um_r   <= um_nxt;
    nneg_r <= nneg_nxt;
    mneg_r <= mneg_nxt;
    cnt_r  <= cnt_nxt;
    out_r  <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

// ===== design/register_alu_stack_executor.sv =====
`timescale 1ns / 1ps
// Executes one decoded instruction per item against a register file, a stack and
// four status flags. An item is taken when start is high and busy is low; items
// land in a two-entry queue, so busy rises only when that queue is full. Each
// item gives one result on out_item, shown for exactly one cycle with out_valid
// high, and the receiver has to take it then. Most items pass through a register
// file read, then execute and write back; swap adds a second write back; divide
// and square run a one-bit-per-cycle shift unit, then square writes its result
// and divide writes quotient and remainder, while a zero divisor ends in execute.
// Results come out in item order.
module register_alu_stack_executor
  import rase_pkg::*;
#(
  parameter int REG_COUNT   = 32,
  parameter int STACK_DEPTH = 32,
  parameter int DATA_WIDTH  = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item
);

  logic     head_valid;
  logic     pop;
  in_item_t head;

  rase_front u_front (
    .clk(clk), .rst_n(rst_n), .start(start), .item(in_item), .busy(busy),
    .pop(pop), .head_valid(head_valid), .head(head)
  );

  rase_back #(
    .REG_COUNT(REG_COUNT), .STACK_DEPTH(STACK_DEPTH), .DATA_WIDTH(DATA_WIDTH)
  ) u_back (
    .clk(clk), .rst_n(rst_n), .head_valid(head_valid), .head(head), .pop(pop),
    .out_valid(out_valid), .out_item(out_item)
  );

endmodule

// ===== bench/register_alu_stack_executor_test.sv =====
`timescale 1ns / 1ps
module register_alu_stack_executor_test;
  import rase_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_item;
  logic      out_valid;
  out_item_t out_item;

  register_alu_stack_executor uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_item(in_item), .out_valid(out_valid), .out_item(out_item)
  );

  // predictor state
  logic [31:0] regs [32];
  logic [31:0] stk [32];
  int          stk_count;
  logic        f_par, f_zero, f_sign, f_ovf;
  logic        skip_next;

  out_item_t   pending_results[$];
  int          mismatch_count;
  int          cycle_count;
  int          burst_left;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  function automatic logic [31:0] neg32(logic [31:0] v);
    return 32'd0 - v;
  endfunction

  function automatic void update_flags(logic [31:0] v);
    f_sign = v[31];
    f_zero = (v == 32'd0);
    f_par  = !v[31] && ^v;
  endfunction

  function automatic out_item_t execute_item(in_item_t it);
    out_item_t   r;
    logic [31:0] x, y, v, n, m, un, um, q, rm, t;
    r = '0;
    if (skip_next) begin
      skip_next = 1'b0;
      r.skipped = 1'b1;
    end else if (it.func <= FN_ORI) begin
      x = regs[it.src_a_reg];
      y = (it.func <= FN_OR) ? regs[it.src_b_reg] : it.immediate;
      case (it.func)
        FN_ADD, FN_ADDI: v = x + y;
        FN_SUB, FN_SUBI: v = x - y;
        FN_AND, FN_ANDI: v = x & y;
        FN_XOR, FN_XORI: v = x ^ y;
        default:         v = x | y;
      endcase
      regs[it.dest_reg] = v;
      r.result_value = v;
      update_flags(v);
      if (it.func == FN_ADD || it.func == FN_ADDI)
        f_ovf = (x[31] == y[31]) && (v[31] != x[31]);
      else if (it.func == FN_SUB || it.func == FN_SUBI)
        f_ovf = (x[31] != y[31]) && (v[31] != x[31]);
    end else begin
      case (it.func)
        FN_MOVREG: begin
          r.result_value = regs[it.src_a_reg];
          regs[it.dest_reg] = regs[it.src_a_reg];
        end
        FN_MOVIMM: begin
          regs[it.dest_reg] = it.immediate;
          r.result_value = it.immediate;
        end
        FN_SWAP: begin
          t = regs[it.dest_reg];
          regs[it.dest_reg] = regs[it.src_a_reg];
          regs[it.src_a_reg] = t;
          r.result_value = regs[it.dest_reg];
          r.second_value = regs[it.src_a_reg];
        end
        FN_DIV: begin
          n = regs[it.dest_reg];
          m = regs[it.src_a_reg];
          if (m == 32'd0) begin
            r.error_code = ERR_DIV0;
          end else begin
            un = n[31] ? neg32(n) : n;
            um = m[31] ? neg32(m) : m;
            q  = un / um;
            rm = un % um;
            if (n[31] != m[31]) q = neg32(q);
            if (n[31]) rm = neg32(rm);
            regs[it.dest_reg] = q;
            regs[it.src_a_reg] = rm;
            r.result_value = q;
            r.second_value = rm;
            update_flags(regs[it.dest_reg]);
          end
        end
        FN_PUSH: begin
          if (stk_count >= 32) begin
            r.error_code = ERR_FULL;
          end else begin
            stk[stk_count] = regs[it.dest_reg];
            stk_count++;
            r.result_value = regs[it.dest_reg];
          end
        end
        FN_POP: begin
          if (stk_count == 0) begin
            r.error_code = ERR_EMPTY;
          end else begin
            stk_count--;
            r.result_value = stk[stk_count];
            regs[it.dest_reg] = stk[stk_count];
          end
        end
        FN_SKIPEQ: if (regs[it.dest_reg] == regs[it.src_a_reg]) skip_next = 1'b1;
        FN_SQUARE: begin
          v = regs[it.dest_reg] * regs[it.dest_reg];
          regs[it.dest_reg] = v;
          r.result_value = v;
        end
        default: ;
      endcase
    end
    r.parity_flag = f_par;
    r.zero_flag = f_zero;
    r.sign_flag = f_sign;
    r.overflow_flag = f_ovf;
    return r;
  endfunction

  // sender: bursts with random gaps
  task automatic send_item(in_item_t it);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    start   <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.push_back(execute_item(it));
  endtask

  function automatic in_item_t make_item(logic [4:0] fn, logic [4:0] d, logic [4:0] a,
                                         logic [4:0] b, logic [31:0] imm);
    in_item_t it;
    it.func = fn;
    it.dest_reg = d;
    it.src_a_reg = a;
    it.src_b_reg = b;
    it.immediate = imm;
    return it;
  endfunction

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return $urandom_range(0, 8);
      4: return -$urandom_range(0, 8);
      default: return $urandom;
    endcase
  endfunction

  task automatic wait_drained();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("register_alu_stack_executor test failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected result %p", out_item);
      end else begin
        want = pending_results.pop_front();
        if (out_item !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("mismatch: expected %p got %p", want, out_item);
        end
      end
    end
  end

  task automatic test_alu_extremes();
    send_item(make_item(FN_MOVIMM, 5'd1, 5'd0, 5'd0, 32'h7fff_ffff));
    send_item(make_item(FN_MOVIMM, 5'd31, 5'd0, 5'd0, 32'h8000_0000));
    send_item(make_item(FN_ADDI, 5'd2, 5'd1, 5'd0, 32'd1));
    send_item(make_item(FN_SUB, 5'd3, 5'd31, 5'd1, 32'd0));
    send_item(make_item(FN_AND, 5'd4, 5'd1, 5'd31, 32'd0));
    send_item(make_item(FN_XOR, 5'd5, 5'd1, 5'd31, 32'd0));
    send_item(make_item(FN_OR, 5'd6, 5'd1, 5'd31, 32'd0));
    send_item(make_item(FN_SUBI, 5'd7, 5'd0, 5'd0, 32'h8000_0000));
    send_item(make_item(FN_ANDI, 5'd8, 5'd1, 5'd0, 32'h5555_aaaa));
    send_item(make_item(FN_XORI, 5'd9, 5'd1, 5'd0, 32'hffff_ffff));
    send_item(make_item(FN_ORI, 5'd10, 5'd0, 5'd0, 32'd7));
    send_item(make_item(FN_MOVREG, 5'd11, 5'd31, 5'd0, 32'd0));
    send_item(make_item(FN_SWAP, 5'd11, 5'd10, 5'd0, 32'd0));
    send_item(make_item(FN_SQUARE, 5'd1, 5'd0, 5'd0, 32'd0));
    send_item(make_item(5'd31, 5'd1, 5'd2, 5'd3, 32'hffff_ffff));
    wait_drained();
  endtask

  task automatic test_divide_cases();
    send_item(make_item(FN_MOVIMM, 5'd12, 5'd0, 5'd0, -32'sd1));
    send_item(make_item(FN_MOVIMM, 5'd13, 5'd0, 5'd0, 32'h8000_0000));
    send_item(make_item(FN_DIV, 5'd13, 5'd12, 5'd0, 32'd0));
    send_item(make_item(FN_DIV, 5'd13, 5'd0, 5'd0, 32'd0));
    send_item(make_item(FN_MOVIMM, 5'd14, 5'd0, 5'd0, -32'sd7));
    send_item(make_item(FN_MOVIMM, 5'd15, 5'd0, 5'd0, 32'd2));
    send_item(make_item(FN_DIV, 5'd14, 5'd15, 5'd0, 32'd0));
    send_item(make_item(FN_DIV, 5'd15, 5'd15, 5'd0, 32'd0));
    wait_drained();
  endtask

  task automatic test_stack_limits();
    send_item(make_item(FN_POP, 5'd1, 5'd0, 5'd0, 32'd0));
    for (int i = 0; i < 33; i++)
      send_item(make_item(FN_PUSH, 5'($urandom), 5'd0, 5'd0, 32'd0));
    for (int i = 0; i < 33; i++)
      send_item(make_item(FN_POP, 5'($urandom), 5'd0, 5'd0, 32'd0));
    wait_drained();
  endtask

  task automatic test_skip_cases();
    send_item(make_item(FN_SKIPEQ, 5'd0, 5'd0, 5'd0, 32'd0));
    send_item(make_item(FN_SKIPEQ, 5'd0, 5'd0, 5'd0, 32'd0));
    send_item(make_item(FN_MOVIMM, 5'd0, 5'd0, 5'd0, 32'd5));
    send_item(make_item(FN_SKIPEQ, 5'd0, 5'd1, 5'd0, 32'd0));
    send_item(make_item(FN_ADDI, 5'd0, 5'd0, 5'd0, 32'd1));
    wait_drained();
  endtask

  task automatic test_random_mix(int count);
    in_item_t it;
    for (int i = 0; i < count; i++) begin
      it = make_item(5'($urandom_range(0, 17)), 5'($urandom), 5'($urandom),
                     5'($urandom), rand_value());
      if ($urandom_range(0, 30) == 0) it.func = 5'($urandom_range(18, 31));
      // keep divides rare, they are slow
      if (it.func == FN_DIV && $urandom_range(0, 2) != 0) it.func = FN_MOVIMM;
      if (it.func == FN_SQUARE && $urandom_range(0, 1) != 0) it.func = FN_ADDI;
      if (it.func == FN_SKIPEQ && $urandom_range(0, 1) == 0) it.src_a_reg = it.dest_reg;
      send_item(it);
      if (i == count / 2) wait_drained();
      // stretch with no gaps
      if (i == count / 4) burst_left = 200;
    end
    wait_drained();
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    mismatch_count = 0;
    cycle_count = 0;
    burst_left = 0;
    for (int i = 0; i < 32; i++) regs[i] = '0;
    stk_count = 0;
    f_par = 0; f_zero = 0; f_sign = 0; f_ovf = 0;
    skip_next = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_alu_extremes();
    test_divide_cases();
    test_stack_limits();
    test_skip_cases();
    test_random_mix(1600);
    repeat (60) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0)
      $display("register_alu_stack_executor test passed");
    else
      $display("register_alu_stack_executor test failed");
    $finish;
  end

endmodule
